FILE: src/cofs_pkg.sv
// Package for the operand fetch sequencer: addressing mode codes and mode decode helpers.
`default_nettype none

package cofs_pkg;

    localparam int MODE_W = 5;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int CYC_W  = 2;

    localparam logic [MODE_W-1:0] MODE_IMP    = 5'd0;
    localparam logic [MODE_W-1:0] MODE_R      = 5'd1;
    localparam logic [MODE_W-1:0] MODE_R_R    = 5'd2;
    localparam logic [MODE_W-1:0] MODE_R_D8   = 5'd3;
    localparam logic [MODE_W-1:0] MODE_R_D16  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_D16    = 5'd5;
    localparam logic [MODE_W-1:0] MODE_MR_R   = 5'd6;
    localparam logic [MODE_W-1:0] MODE_R_MR   = 5'd7;
    localparam logic [MODE_W-1:0] MODE_R_HLI  = 5'd8;
    localparam logic [MODE_W-1:0] MODE_R_HLD  = 5'd9;
    localparam logic [MODE_W-1:0] MODE_HLI_R  = 5'd10;
    localparam logic [MODE_W-1:0] MODE_HLD_R  = 5'd11;
    localparam logic [MODE_W-1:0] MODE_R_A8   = 5'd12;
    localparam logic [MODE_W-1:0] MODE_A8_R   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_HL_SPR = 5'd14;
    localparam logic [MODE_W-1:0] MODE_D8     = 5'd15;
    localparam logic [MODE_W-1:0] MODE_A16_R  = 5'd16;
    localparam logic [MODE_W-1:0] MODE_D16_R  = 5'd17;
    localparam logic [MODE_W-1:0] MODE_MR_D8  = 5'd18;
    localparam logic [MODE_W-1:0] MODE_MR     = 5'd19;
    localparam logic [MODE_W-1:0] MODE_R_A16  = 5'd20;

    localparam logic [WORD_W-1:0] HIGH_PAGE = 16'hFF00;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic FUNC_START = 1'b0;

    function automatic logic [1:0] pc_advance(input logic [MODE_W-1:0] m);
        logic [1:0] adv;
        unique case (m) inside
            MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16:
                adv = 2'd2;
            MODE_IMP, MODE_R, MODE_R_R, MODE_MR_R, MODE_R_MR, MODE_R_HLI,
            MODE_R_HLD, MODE_HLI_R, MODE_HLD_R, MODE_MR:
                adv = 2'd0;
            default:
                adv = 2'd1;
        endcase
        return adv;
    endfunction

    function automatic logic dest_mem(input logic [MODE_W-1:0] m);
        return (m == MODE_MR_R) || (m == MODE_HLI_R) || (m == MODE_HLD_R) ||
               (m == MODE_A8_R) || (m == MODE_A16_R) || (m == MODE_D16_R) ||
               (m == MODE_MR_D8) || (m == MODE_MR);
    endfunction

    function automatic logic hl_steps(input logic [MODE_W-1:0] m);
        return (m == MODE_R_HLI) || (m == MODE_R_HLD) ||
               (m == MODE_HLI_R) || (m == MODE_HLD_R);
    endfunction

endpackage

`default_nettype wire

FILE: src/cpu_operand_fetch_sequencer.sv
// Operand fetch sequencer: decodes addressing modes, requests bus reads, reports the operand.
//
// A start item (s_func low) opens an operand fetch; it either finishes at once or asks for a
// bus read. Each returned byte comes back as an item with s_func high and yields the next read
// request or the finished report. Data items that arrive with no fetch under way are dropped
// and give no result. A start while a fetch is under way abandons it. Every item is handled by
// combinational decode logic and its result appears in the output register in the cycle after
// acceptance; one item is taken per clock, limited only by that output register draining.
`default_nettype none

module cpu_operand_fetch_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [4:0]  s_mode,
    input  wire logic [15:0] s_reg1_value,
    input  wire logic [15:0] s_reg2_value,
    input  wire logic        s_reg1_is_c,
    input  wire logic        s_reg2_is_c,
    input  wire logic [15:0] s_hl_value,
    input  wire logic [15:0] s_pc_value,
    input  wire logic [7:0]  s_bus_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [15:0]      m_read_address,
    output logic [15:0]      m_fetched_value,
    output logic [15:0]      m_dest_address,
    output logic             m_dest_is_memory,
    output logic [15:0]      m_next_pc,
    output logic [15:0]      m_next_hl,
    output logic             m_hl_written,
    output logic [1:0]       m_bus_cycles,
    output logic             m_bad_mode
);

    logic        busy_reg, busy_next;
    logic [4:0]  mode_reg, mode_next;
    logic [1:0]  step_reg, step_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] operand_reg, operand_next;
    logic [15:0] dest_reg, dest_next;
    logic [15:0] hl_reg, hl_next;

    logic        m_valid_reg;
    logic        kind_reg;
    logic [15:0] read_address_reg;
    logic [15:0] fetched_value_reg;
    logic [15:0] dest_address_reg;
    logic        dest_is_memory_reg;
    logic [15:0] next_pc_reg;
    logic [15:0] next_hl_reg;
    logic        hl_written_reg;
    logic [1:0]  bus_cycles_reg;
    logic        bad_mode_reg;

    logic        accept;
    logic        emit_req;
    logic        emit_fin;
    logic        bad;
    logic [15:0] req_addr;
    logic [1:0]  done;
    logic [15:0] word;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        busy_next     = busy_reg;
        mode_next     = mode_reg;
        step_next     = step_reg;
        low_byte_next = low_byte_reg;
        pc_next       = pc_reg;
        operand_next  = operand_reg;
        dest_next     = dest_reg;
        hl_next       = hl_reg;
        emit_req      = 1'b0;
        emit_fin      = 1'b0;
        bad           = 1'b0;
        req_addr      = '0;
        done          = '0;
        word          = {s_bus_data, low_byte_reg};
        if (accept) begin
            if (s_func == cofs_pkg::FUNC_START) begin
                mode_next = s_mode;
                step_next = '0;
                pc_next   = s_pc_value;
                hl_next   = s_hl_value;
                dest_next = '0;
                unique case (s_mode) inside
                    cofs_pkg::MODE_IMP: begin
                        emit_fin = 1'b1;
                    end
                    cofs_pkg::MODE_R: begin
                        operand_next = s_reg1_value;
                        emit_fin     = 1'b1;
                    end
                    cofs_pkg::MODE_R_R: begin
                        operand_next = s_reg2_value;
                        emit_fin     = 1'b1;
                    end
                    cofs_pkg::MODE_MR_R: begin
                        operand_next = s_reg2_value;
                        dest_next    = s_reg1_is_c ? (s_reg1_value | cofs_pkg::HIGH_PAGE)
                                                   : s_reg1_value;
                        emit_fin     = 1'b1;
                    end
                    cofs_pkg::MODE_HLI_R: begin
                        operand_next = s_reg2_value;
                        dest_next    = s_hl_value;
                        hl_next      = s_hl_value + 16'd1;
                        emit_fin     = 1'b1;
                    end
                    cofs_pkg::MODE_HLD_R: begin
                        operand_next = s_reg2_value;
                        dest_next    = s_hl_value;
                        hl_next      = s_hl_value - 16'd1;
                        emit_fin     = 1'b1;
                    end
                    cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R: begin
                        operand_next = s_reg2_value;
                        req_addr     = s_pc_value;
                        emit_req     = 1'b1;
                    end
                    cofs_pkg::MODE_MR_D8: begin
                        dest_next = s_reg1_value;
                        req_addr  = s_pc_value;
                        emit_req  = 1'b1;
                    end
                    cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16,
                    cofs_pkg::MODE_R_A8, cofs_pkg::MODE_A8_R, cofs_pkg::MODE_HL_SPR,
                    cofs_pkg::MODE_D8, cofs_pkg::MODE_R_A16: begin
                        req_addr = s_pc_value;
                        emit_req = 1'b1;
                    end
                    cofs_pkg::MODE_R_MR: begin
                        req_addr = s_reg2_is_c ? (s_reg2_value | cofs_pkg::HIGH_PAGE)
                                               : s_reg2_value;
                        emit_req = 1'b1;
                    end
                    cofs_pkg::MODE_R_HLI: begin
                        hl_next  = s_hl_value + 16'd1;
                        req_addr = s_reg2_value;
                        emit_req = 1'b1;
                    end
                    cofs_pkg::MODE_R_HLD: begin
                        hl_next  = s_hl_value - 16'd1;
                        req_addr = s_reg2_value;
                        emit_req = 1'b1;
                    end
                    cofs_pkg::MODE_MR: begin
                        dest_next = s_reg1_value;
                        req_addr  = s_reg1_value;
                        emit_req  = 1'b1;
                    end
                    default: begin
                        bad      = 1'b1;
                        emit_fin = 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                done      = step_reg + 2'd1;
                step_next = done;
                unique case (mode_reg) inside
                    cofs_pkg::MODE_A8_R: begin
                        dest_next = cofs_pkg::HIGH_PAGE | {8'h00, s_bus_data};
                        emit_fin  = 1'b1;
                    end
                    cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
                    cofs_pkg::MODE_D16_R, cofs_pkg::MODE_R_A16: begin
                        if (done == 2'd1) begin
                            low_byte_next = s_bus_data;
                            req_addr      = pc_reg + 16'd1;
                            emit_req      = 1'b1;
                        end else if (done == 2'd2) begin
                            if (mode_reg == cofs_pkg::MODE_R_D16 ||
                                mode_reg == cofs_pkg::MODE_D16) begin
                                operand_next = word;
                                emit_fin     = 1'b1;
                            end else begin
                                dest_next = word;
                                if (mode_reg == cofs_pkg::MODE_R_A16) begin
                                    req_addr = word;
                                    emit_req = 1'b1;
                                end else begin
                                    emit_fin = 1'b1;
                                end
                            end
                        end else begin
                            operand_next = {8'h00, s_bus_data};
                            emit_fin     = 1'b1;
                        end
                    end
                    default: begin
                        operand_next = {8'h00, s_bus_data};
                        emit_fin     = 1'b1;
                    end
                endcase
            end
        end
        if (emit_fin) begin
            busy_next = 1'b0;
            step_next = '0;
        end
        if (emit_req) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            mode_reg     <= '0;
            step_reg     <= '0;
            low_byte_reg <= '0;
            pc_reg       <= '0;
            operand_reg  <= '0;
            dest_reg     <= '0;
            hl_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            mode_reg     <= mode_next;
            step_reg     <= step_next;
            low_byte_reg <= low_byte_next;
            pc_reg       <= pc_next;
            operand_reg  <= operand_next;
            dest_reg     <= dest_next;
            hl_reg       <= hl_next;
            if (s_ready) begin
                m_valid_reg <= emit_req || emit_fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_req) begin
            kind_reg           <= cofs_pkg::KIND_READ;
            read_address_reg   <= req_addr;
            fetched_value_reg  <= '0;
            dest_address_reg   <= '0;
            dest_is_memory_reg <= 1'b0;
            next_pc_reg        <= '0;
            next_hl_reg        <= '0;
            hl_written_reg     <= 1'b0;
            bus_cycles_reg     <= '0;
            bad_mode_reg       <= 1'b0;
        end else if (emit_fin) begin
            kind_reg           <= cofs_pkg::KIND_FINISH;
            read_address_reg   <= '0;
            fetched_value_reg  <= operand_next;
            dest_address_reg   <= cofs_pkg::dest_mem(mode_next) ? dest_next : 16'h0000;
            dest_is_memory_reg <= cofs_pkg::dest_mem(mode_next);
            next_pc_reg        <= pc_next + {14'b0, cofs_pkg::pc_advance(mode_next)};
            next_hl_reg        <= hl_next;
            hl_written_reg     <= cofs_pkg::hl_steps(mode_next);
            bus_cycles_reg     <= done;
            bad_mode_reg       <= bad;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_read_address   = read_address_reg;
    assign m_fetched_value  = fetched_value_reg;
    assign m_dest_address   = dest_address_reg;
    assign m_dest_is_memory = dest_is_memory_reg;
    assign m_next_pc        = next_pc_reg;
    assign m_next_hl        = next_hl_reg;
    assign m_hl_written     = hl_written_reg;
    assign m_bus_cycles     = bus_cycles_reg;
    assign m_bad_mode       = bad_mode_reg;

endmodule

`default_nettype wire

FILE: tb/cpu_operand_fetch_sequencer_test.sv
// Testbench for the operand fetch sequencer: directed and random fetches checked against a predictor.
`timescale 1ns / 100ps

module cpu_operand_fetch_sequencer_test;

    localparam logic            FUNC_DATA          = 1'b1;
    localparam logic [4:0]      MODE_FIRST_UNKNOWN = 5'd21;
    localparam logic [4:0]      MODE_LAST_UNKNOWN  = 5'd31;
    localparam int              CYCLE_LIMIT        = 200000;
    localparam int              DRAIN_CYCLES       = 20;
    localparam int              LONG_HOLD          = 150;

    typedef struct packed {
        logic        func;
        logic [4:0]  mode;
        logic [15:0] reg1;
        logic [15:0] reg2;
        logic        reg1_c;
        logic        reg2_c;
        logic [15:0] hl;
        logic [15:0] pc;
        logic [7:0]  data;
    } fetch_in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] read_address;
        logic [15:0] fetched_value;
        logic [15:0] dest_address;
        logic        dest_is_memory;
        logic [15:0] next_pc;
        logic [15:0] next_hl;
        logic        hl_written;
        logic [1:0]  bus_cycles;
        logic        bad_mode;
    } fetch_out_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [4:0]  s_mode;
    logic [15:0] s_reg1_value;
    logic [15:0] s_reg2_value;
    logic        s_reg1_is_c;
    logic        s_reg2_is_c;
    logic [15:0] s_hl_value;
    logic [15:0] s_pc_value;
    logic [7:0]  s_bus_data;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [15:0] m_read_address;
    logic [15:0] m_fetched_value;
    logic [15:0] m_dest_address;
    logic        m_dest_is_memory;
    logic [15:0] m_next_pc;
    logic [15:0] m_next_hl;
    logic        m_hl_written;
    logic [1:0]  m_bus_cycles;
    logic        m_bad_mode;

    logic        sq_busy;
    logic [4:0]  sq_mode;
    logic [1:0]  sq_reads;
    logic [7:0]  sq_imm_low;
    logic [15:0] sq_pc;
    logic [15:0] sq_operand;
    logic [15:0] sq_dest;
    logic [15:0] sq_hl;

    fetch_out_t  pending_results[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_gaps = 1'b1;

    cpu_operand_fetch_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_mode           (s_mode),
        .s_reg1_value     (s_reg1_value),
        .s_reg2_value     (s_reg2_value),
        .s_reg1_is_c      (s_reg1_is_c),
        .s_reg2_is_c      (s_reg2_is_c),
        .s_hl_value       (s_hl_value),
        .s_pc_value       (s_pc_value),
        .s_bus_data       (s_bus_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_read_address   (m_read_address),
        .m_fetched_value  (m_fetched_value),
        .m_dest_address   (m_dest_address),
        .m_dest_is_memory (m_dest_is_memory),
        .m_next_pc        (m_next_pc),
        .m_next_hl        (m_next_hl),
        .m_hl_written     (m_hl_written),
        .m_bus_cycles     (m_bus_cycles),
        .m_bad_mode       (m_bad_mode)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void queue_read(input logic [15:0] addr);
        fetch_out_t r;
        r = '0;
        r.kind = cofs_pkg::KIND_READ;
        r.read_address = addr;
        pending_results.push_back(r);
        sq_busy = 1'b1;
    endfunction

    function automatic void queue_finish(input logic [1:0] cycles, input logic bad);
        fetch_out_t r;
        logic [15:0] adv;
        logic        mem;
        mem = (sq_mode == cofs_pkg::MODE_MR_R) || (sq_mode == cofs_pkg::MODE_HLI_R) ||
              (sq_mode == cofs_pkg::MODE_HLD_R) || (sq_mode == cofs_pkg::MODE_A8_R) ||
              (sq_mode == cofs_pkg::MODE_A16_R) || (sq_mode == cofs_pkg::MODE_D16_R) ||
              (sq_mode == cofs_pkg::MODE_MR_D8) || (sq_mode == cofs_pkg::MODE_MR);
        case (sq_mode)
            cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
            cofs_pkg::MODE_D16_R, cofs_pkg::MODE_R_A16: adv = 16'd2;
            cofs_pkg::MODE_IMP, cofs_pkg::MODE_R, cofs_pkg::MODE_R_R, cofs_pkg::MODE_MR_R,
            cofs_pkg::MODE_R_MR, cofs_pkg::MODE_R_HLI, cofs_pkg::MODE_R_HLD,
            cofs_pkg::MODE_HLI_R, cofs_pkg::MODE_HLD_R, cofs_pkg::MODE_MR: adv = 16'd0;
            default: adv = 16'd1;
        endcase
        r.kind = cofs_pkg::KIND_FINISH;
        r.read_address = 16'h0000;
        r.fetched_value = sq_operand;
        r.dest_address = mem ? sq_dest : 16'h0000;
        r.dest_is_memory = mem;
        r.next_pc = sq_pc + adv;
        r.next_hl = sq_hl;
        r.hl_written = (sq_mode == cofs_pkg::MODE_R_HLI) || (sq_mode == cofs_pkg::MODE_R_HLD) ||
                       (sq_mode == cofs_pkg::MODE_HLI_R) || (sq_mode == cofs_pkg::MODE_HLD_R);
        r.bus_cycles = cycles;
        r.bad_mode = bad;
        pending_results.push_back(r);
        sq_busy = 1'b0;
        sq_reads = 2'd0;
    endfunction

    function automatic void predict_fetch_step(input fetch_in_t it);
        logic [1:0]  done;
        logic [15:0] word;
        if (it.func == cofs_pkg::FUNC_START) begin
            sq_busy = 1'b0;
            sq_mode = it.mode;
            sq_reads = 2'd0;
            sq_pc = it.pc;
            sq_hl = it.hl;
            sq_dest = 16'h0000;
            case (it.mode)
                cofs_pkg::MODE_IMP: queue_finish(2'd0, 1'b0);
                cofs_pkg::MODE_R: begin
                    sq_operand = it.reg1;
                    queue_finish(2'd0, 1'b0);
                end
                cofs_pkg::MODE_R_R: begin
                    sq_operand = it.reg2;
                    queue_finish(2'd0, 1'b0);
                end
                cofs_pkg::MODE_MR_R: begin
                    sq_operand = it.reg2;
                    sq_dest = it.reg1_c ? (it.reg1 | cofs_pkg::HIGH_PAGE) : it.reg1;
                    queue_finish(2'd0, 1'b0);
                end
                cofs_pkg::MODE_HLI_R, cofs_pkg::MODE_HLD_R: begin
                    sq_operand = it.reg2;
                    sq_dest = it.hl;
                    sq_hl = (it.mode == cofs_pkg::MODE_HLI_R) ? it.hl + 16'd1 : it.hl - 16'd1;
                    queue_finish(2'd0, 1'b0);
                end
                cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R: begin
                    sq_operand = it.reg2;
                    queue_read(it.pc);
                end
                cofs_pkg::MODE_MR_D8: begin
                    sq_dest = it.reg1;
                    queue_read(it.pc);
                end
                cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16,
                cofs_pkg::MODE_R_A8, cofs_pkg::MODE_A8_R, cofs_pkg::MODE_HL_SPR,
                cofs_pkg::MODE_D8, cofs_pkg::MODE_R_A16: queue_read(it.pc);
                cofs_pkg::MODE_R_MR:
                    queue_read(it.reg2_c ? (it.reg2 | cofs_pkg::HIGH_PAGE) : it.reg2);
                cofs_pkg::MODE_R_HLI, cofs_pkg::MODE_R_HLD: begin
                    sq_hl = (it.mode == cofs_pkg::MODE_R_HLI) ? it.hl + 16'd1 : it.hl - 16'd1;
                    queue_read(it.reg2);
                end
                cofs_pkg::MODE_MR: begin
                    sq_dest = it.reg1;
                    queue_read(it.reg1);
                end
                default: queue_finish(2'd0, 1'b1);
            endcase
        end else if (sq_busy) begin
            done = sq_reads + 2'd1;
            sq_reads = done;
            case (sq_mode)
                cofs_pkg::MODE_A8_R: begin
                    sq_dest = cofs_pkg::HIGH_PAGE | {8'h00, it.data};
                    queue_finish(done, 1'b0);
                end
                cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
                cofs_pkg::MODE_D16_R, cofs_pkg::MODE_R_A16: begin
                    if (done == 2'd1) begin
                        sq_imm_low = it.data;
                        queue_read(sq_pc + 16'd1);
                    end else if (done == 2'd2) begin
                        word = {it.data, sq_imm_low};
                        if (sq_mode == cofs_pkg::MODE_R_D16 || sq_mode == cofs_pkg::MODE_D16) begin
                            sq_operand = word;
                            queue_finish(done, 1'b0);
                        end else begin
                            sq_dest = word;
                            if (sq_mode == cofs_pkg::MODE_R_A16)
                                queue_read(word);
                            else
                                queue_finish(done, 1'b0);
                        end
                    end else begin
                        sq_operand = {8'h00, it.data};
                        queue_finish(done, 1'b0);
                    end
                end
                default: begin
                    sq_operand = {8'h00, it.data};
                    queue_finish(done, 1'b0);
                end
            endcase
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_checker
        fetch_in_t  seen;
        fetch_out_t want;
        if (aresetn && s_valid && s_ready) begin
            seen = {s_func, s_mode, s_reg1_value, s_reg2_value, s_reg1_is_c, s_reg2_is_c,
                    s_hl_value, s_pc_value, s_bus_data};
            predict_fetch_step(seen);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d, read_address %h",
                       m_kind, m_read_address);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(m_kind));
                check_field("read_address", want.read_address, m_read_address);
                check_field("fetched_value", want.fetched_value, m_fetched_value);
                check_field("dest_address", want.dest_address, m_dest_address);
                check_field("dest_is_memory", 16'(want.dest_is_memory),
                            16'(m_dest_is_memory));
                check_field("next_pc", want.next_pc, m_next_pc);
                check_field("next_hl", want.next_hl, m_next_hl);
                check_field("hl_written", 16'(want.hl_written), 16'(m_hl_written));
                check_field("bus_cycles", 16'(want.bus_cycles), 16'(m_bus_cycles));
                check_field("bad_mode", 16'(want.bad_mode), 16'(m_bad_mode));
            end
        end
    end

    initial begin : result_receiver
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                for (n = 0; n < hold_cycles; n++)
                    @(negedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick16();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick8();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hFF;
            default: v = 8'($urandom_range(0, 8'hFF));
        endcase
        return v;
    endfunction

    function automatic fetch_in_t start_item(input logic [4:0] mode);
        fetch_in_t it;
        it.func = cofs_pkg::FUNC_START;
        it.mode = mode;
        it.reg1 = pick16();
        it.reg2 = pick16();
        it.reg1_c = 1'($urandom_range(0, 1));
        it.reg2_c = 1'($urandom_range(0, 1));
        it.hl = pick16();
        it.pc = pick16();
        it.data = pick8();
        return it;
    endfunction

    function automatic fetch_in_t data_item(input logic [7:0] b);
        fetch_in_t it;
        it = start_item(5'($urandom_range(0, 31)));
        it.func = FUNC_DATA;
        it.data = b;
        return it;
    endfunction

    function automatic int reads_for(input logic [4:0] mode);
        int n;
        case (mode)
            cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_A8, cofs_pkg::MODE_A8_R,
            cofs_pkg::MODE_HL_SPR, cofs_pkg::MODE_D8, cofs_pkg::MODE_MR_D8,
            cofs_pkg::MODE_R_MR, cofs_pkg::MODE_R_HLI, cofs_pkg::MODE_R_HLD,
            cofs_pkg::MODE_MR: n = 1;
            cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
            cofs_pkg::MODE_D16_R: n = 2;
            cofs_pkg::MODE_R_A16: n = 3;
            default: n = 0;
        endcase
        return n;
    endfunction

    task automatic idle_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_item(input fetch_in_t it);
        if (sender_gaps && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 15));
        @(negedge aclk);
        s_func <= it.func;
        s_mode <= it.mode;
        s_reg1_value <= it.reg1;
        s_reg2_value <= it.reg2;
        s_reg1_is_c <= it.reg1_c;
        s_reg2_is_c <= it.reg2_c;
        s_hl_value <= it.hl;
        s_pc_value <= it.pc;
        s_bus_data <= it.data;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic run_fetch(input fetch_in_t start, input int reads);
        send_item(start);
        repeat (reads) send_item(data_item(pick8()));
        items_sent += reads + 1;
    endtask

    task automatic random_fetch();
        logic [4:0] mode;
        int         n;
        if ($urandom_range(0, 3) == 0)
            mode = 5'($urandom_range(0, 31));
        else
            mode = 5'($urandom_range(0, cofs_pkg::MODE_R_A16));
        n = reads_for(mode);
        if (n > 0 && $urandom_range(0, 9) == 0)
            n = $urandom_range(0, n - 1);
        run_fetch(start_item(mode), n);
        if ($urandom_range(0, 14) == 0)
            send_item(data_item(pick8()));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_data_while_idle();
        send_item(data_item(8'hFF));
        send_item(data_item(8'h00));
    endtask

    task automatic test_every_mode();
        fetch_in_t it;
        int        m;
        for (m = cofs_pkg::MODE_IMP; m <= cofs_pkg::MODE_R_A16; m++) begin
            it = start_item(5'(m));
            it.reg1 = m[0] ? 16'hFFFF : 16'h0000;
            it.reg2 = ~it.reg1;
            it.hl = m[1] ? 16'hFFFF : 16'h0000;
            it.pc = m[2] ? 16'hFFFF : 16'h0000;
            it.reg1_c = m[0];
            it.reg2_c = m[1];
            run_fetch(it, reads_for(5'(m)));
        end
        run_fetch(start_item(MODE_FIRST_UNKNOWN), 0);
        run_fetch(start_item(MODE_LAST_UNKNOWN), 0);
    endtask

    task automatic test_special_cases();
        fetch_in_t it;
        it = start_item(cofs_pkg::MODE_MR_R);
        it.reg1 = 16'h0012;
        it.reg1_c = 1'b1;
        run_fetch(it, 0);
        it = start_item(cofs_pkg::MODE_R_MR);
        it.reg2 = 16'h0044;
        it.reg2_c = 1'b1;
        run_fetch(it, 1);
        it = start_item(cofs_pkg::MODE_HLI_R);
        it.hl = 16'hFFFF;
        run_fetch(it, 0);
        it = start_item(cofs_pkg::MODE_HLD_R);
        it.hl = 16'h0000;
        run_fetch(it, 0);
        it = start_item(cofs_pkg::MODE_R_HLI);
        it.hl = 16'hFFFF;
        run_fetch(it, 1);
        it = start_item(cofs_pkg::MODE_R_HLD);
        it.hl = 16'h0000;
        run_fetch(it, 1);
        it = start_item(cofs_pkg::MODE_D16);
        it.pc = 16'hFFFF;
        send_item(it);
        send_item(data_item(8'hFF));
        send_item(data_item(8'h00));
        items_sent += 3;
        run_fetch(start_item(cofs_pkg::MODE_A8_R), 1);
        run_fetch(start_item(cofs_pkg::MODE_R_A16), 3);
        run_fetch(start_item(cofs_pkg::MODE_R_A16), 1);
        run_fetch(start_item(cofs_pkg::MODE_IMP), 0);
        run_fetch(start_item(cofs_pkg::MODE_D16_R), 1);
        run_fetch(start_item(cofs_pkg::MODE_MR_R), 0);
        send_item(data_item(8'h5A));
    endtask

    task automatic test_random_fetches(input int target);
        while (items_sent < target)
            random_fetch();
    endtask

    task automatic test_output_stall();
        sender_gaps = 1'b0;
        hold_cycles = LONG_HOLD;
        repeat (25) random_fetch();
        sender_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            wait_drained();
            random_fetch();
            random_fetch();
        end
    endtask

    task automatic test_no_idling(input int target);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        while (items_sent < target)
            random_fetch();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = cofs_pkg::FUNC_START;
        s_mode = cofs_pkg::MODE_IMP;
        s_reg1_value = 16'h0000;
        s_reg2_value = 16'h0000;
        s_reg1_is_c = 1'b0;
        s_reg2_is_c = 1'b0;
        s_hl_value = 16'h0000;
        s_pc_value = 16'h0000;
        s_bus_data = 8'h00;
        sq_busy = 1'b0;
        sq_mode = cofs_pkg::MODE_IMP;
        sq_reads = 2'd0;
        sq_imm_low = 8'h00;
        sq_pc = 16'h0000;
        sq_operand = 16'h0000;
        sq_dest = 16'h0000;
        sq_hl = 16'h0000;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_data_while_idle();
        test_every_mode();
        test_special_cases();
        test_random_fetches(330);
        test_output_stall();
        test_drain_pause();
        test_no_idling(460);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/cofs_pkg.sv
src/cpu_operand_fetch_sequencer.sv
tb/cpu_operand_fetch_sequencer_test.sv
